### hdl/smap_pkg.sv
`timescale 1ns / 1ps
package smap_pkg;
   localparam int DEF_MAX_MSG_BYTES = 1024;
   localparam int HDR_BYTES = 20;
   localparam int KEY_BYTES = 16;
   localparam logic [7:0] FAMILY_V4 = 8'h01;
   localparam logic [10:0] RST_MAX_LEN = 11'd548;
   localparam logic [15:0] RST_XOR_TYPE = 16'd32;
   localparam logic [10:0] COUNT_SAT = 11'd2047;
   localparam logic [10:0] LIM_CAP = 11'd2046;
   localparam int QDEPTH = 4;

   localparam logic [0:0] CSR_MAX_LEN = 1'b0;
   localparam logic [0:0] CSR_XOR_TYPE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_SHORT = 3'd2, ST_LONG = 3'd3, ST_TRUNC = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_TYPE_HI = 3'd0, PH_TYPE_LO = 3'd1, PH_LEN_HI = 3'd2, PH_LEN_LO = 3'd3,
      PH_VALUE = 3'd4, PH_PAD = 3'd5
   } phase_type;

   // One classified beat handed from the front to the back part.
   typedef struct packed {
      logic        emit_val;
      logic        emit_sts;
      logic [15:0] attr_type;
      logic [9:0]  byte_index;
      logic [7:0]  data;
      logic        attr_last;
      logic [15:0] msg_type;
      logic [15:0] msg_len;
      status_type  status;
   } work_type;
endpackage

### hdl/smap_front.sv
`timescale 1ns / 1ps
module smap_front import smap_pkg::*; #(
   parameter int MAX_MSG_BYTES = DEF_MAX_MSG_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [7:0]  in_byte,
   input  logic        in_last,
   input  logic [10:0] max_len,
   input  logic [15:0] xor_type,
   output logic        wr_en,
   output work_type    wr_item,
   input  logic        q_full
);
   localparam logic [10:0] PARAM_LIM = (MAX_MSG_BYTES > 2046) ? 11'd2046 :
                                       11'(MAX_MSG_BYTES);

   logic [10:0] count_ff, count_in;
   logic [15:0] htype_ff, htype_in, hlen_ff, hlen_in;
   logic [7:0]  key_ff [KEY_BYTES];
   phase_type   phase_ff, phase_in;
   logic [15:0] ctype_ff, ctype_in, clen_ff, clen_in, vpos_ff, vpos_in;
   logic [7:0]  fam_ff, fam_in;
   logic [15:0] off_ff, off_in;

   logic        fire, emit;
   logic [7:0]  dec;
   logic [15:0] k;
   logic        endv;
   logic [1:0]  pad;
   logic [10:0] lim;
   logic [15:0] htype_n, hlen_n;
   phase_type   phase_n;
   logic [15:0] off_n;
   status_type  st;

   assign in_ready = !q_full;
   assign fire = in_valid && in_ready;

   always_comb begin
      count_in = count_ff;
      htype_in = htype_ff;
      hlen_in = hlen_ff;
      phase_in = phase_ff;
      ctype_in = ctype_ff;
      clen_in = clen_ff;
      vpos_in = vpos_ff;
      fam_in = fam_ff;
      off_in = off_ff;
      emit = 1'b0;
      dec = in_byte;
      endv = (vpos_ff + 16'd1 == clen_ff);
      pad = 2'd0 - clen_ff[1:0];
      k = vpos_ff - 16'd4;
      if (count_ff < 11'(HDR_BYTES)) begin
         unique case (count_ff[4:0])
            5'd0: htype_in = {in_byte, 8'h00};
            5'd1: htype_in = {htype_ff[15:8], in_byte};
            5'd2: hlen_in = {in_byte, 8'h00};
            5'd3: hlen_in = {hlen_ff[15:8], in_byte};
            default: ;
         endcase
      end else begin
         if (!(phase_ff == PH_TYPE_HI && off_ff >= hlen_ff)) begin
            if (off_ff != 16'hFFFF) off_in = off_ff + 16'd1;
            unique case (phase_ff)
               PH_TYPE_HI: begin
                  ctype_in = {in_byte, 8'h00};
                  phase_in = PH_TYPE_LO;
               end
               PH_TYPE_LO: begin
                  ctype_in = {ctype_ff[15:8], in_byte};
                  phase_in = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  clen_in = {in_byte, 8'h00};
                  phase_in = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  clen_in = {clen_ff[15:8], in_byte};
                  vpos_in = '0;
                  fam_in = '0;
                  phase_in = ({clen_ff[15:8], in_byte} == 16'd0) ? PH_TYPE_HI : PH_VALUE;
               end
               PH_VALUE: begin
                  emit = 1'b1;
                  if (ctype_ff == xor_type) begin
                     if (vpos_ff == 16'd1) fam_in = in_byte;
                     else if (vpos_ff == 16'd2) dec = in_byte ^ key_ff[0];
                     else if (vpos_ff == 16'd3) dec = in_byte ^ key_ff[1];
                     else if (vpos_ff >= 16'd4 &&
                              k < ((fam_ff == FAMILY_V4) ? 16'd4 : 16'd16))
                        dec = in_byte ^ key_ff[k[3:0]];
                  end
                  if (endv) begin
                     vpos_in = '0;
                     phase_in = (pad == 2'd0) ? PH_TYPE_HI : PH_PAD;
                  end else begin
                     vpos_in = vpos_ff + 16'd1;
                  end
               end
               PH_PAD: begin
                  vpos_in = vpos_ff + 16'd1;
                  if (vpos_in >= {14'd0, pad}) begin
                     vpos_in = '0;
                     phase_in = PH_TYPE_HI;
                  end
               end
               default: ;
            endcase
         end
      end
      if (count_ff != COUNT_SAT) count_in = count_ff + 11'd1;
      htype_n = htype_in;
      hlen_n = hlen_in;
      phase_n = phase_in;
      off_n = off_in;
      if (in_last) begin
         count_in = '0;
         htype_in = '0;
         hlen_in = '0;
         phase_in = PH_TYPE_HI;
         ctype_in = '0;
         clen_in = '0;
         vpos_in = '0;
         fam_in = '0;
         off_in = '0;
      end
   end

   always_comb begin
      lim = (max_len > PARAM_LIM) ? PARAM_LIM : max_len;
      if (lim > LIM_CAP) lim = LIM_CAP;
      priority if (count_in > lim && !in_last) st = ST_OK;
      else if ((count_ff == COUNT_SAT ? COUNT_SAT : count_ff + 11'd1) > lim) st = ST_LONG;
      else if (count_ff + 11'd1 < 11'(HDR_BYTES)) st = ST_SHORT;
      else if (hlen_n == 16'd0) st = ST_EMPTY;
      else if (off_n < hlen_n || phase_n != PH_TYPE_HI) st = ST_TRUNC;
      else st = ST_OK;
   end

   always_comb begin
      wr_en = fire && (emit || in_last);
      wr_item.emit_val = emit;
      wr_item.emit_sts = in_last;
      wr_item.attr_type = ctype_ff;
      wr_item.byte_index = vpos_ff[9:0];
      wr_item.data = dec;
      wr_item.attr_last = endv;
      wr_item.msg_type = htype_n;
      wr_item.msg_len = hlen_n;
      wr_item.status = st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         htype_ff <= '0;
         hlen_ff <= '0;
         phase_ff <= PH_TYPE_HI;
         ctype_ff <= '0;
         clen_ff <= '0;
         vpos_ff <= '0;
         fam_ff <= '0;
         off_ff <= '0;
      end else if (fire) begin
         count_ff <= count_in;
         htype_ff <= htype_in;
         hlen_ff <= hlen_in;
         phase_ff <= phase_in;
         ctype_ff <= ctype_in;
         clen_ff <= clen_in;
         vpos_ff <= vpos_in;
         fam_ff <= fam_in;
         off_ff <= off_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && count_ff >= 11'd4 && count_ff < 11'(HDR_BYTES))
         key_ff[4'(count_ff - 11'd4)] <= in_byte;
   end
endmodule

### hdl/smap_back.sv
`timescale 1ns / 1ps
module smap_back import smap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  work_type    wr_item,
   output logic        q_full,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [15:0] rsp_attr_type,
   output logic [9:0]  rsp_byte_index,
   output logic [7:0]  rsp_data,
   output logic        rsp_attr_last,
   output logic [15:0] rsp_msg_type,
   output logic [15:0] rsp_msg_len,
   output logic [2:0]  rsp_status
);
   localparam int AW = $clog2(QDEPTH);
   work_type    q_ff [QDEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff, cnt_in;
   logic        half_ff, half_in;
   logic        pop, last_part;
   work_type    head;

   assign head = q_ff[rp_ff];
   // A beat with a value byte and a status shows the value first, then the status.
   assign last_part = !(head.emit_val && head.emit_sts) || half_ff;
   assign rsp_valid = cnt_ff != '0;
   assign pop = rsp_valid && rsp_ready && last_part;
   // Keep one slot spare so a write this cycle never overruns.
   assign q_full = cnt_ff >= (AW + 1)'(QDEPTH - 1);
   assign cnt_in = cnt_ff + (AW + 1)'(wr_en) - (AW + 1)'(pop);

   always_comb begin
      half_in = half_ff;
      if (rsp_valid && rsp_ready) half_in = !last_part;
   end

   always_comb begin
      if (head.emit_val && !half_ff) begin
         rsp_kind = 1'b0;
         rsp_attr_type = head.attr_type;
         rsp_byte_index = head.byte_index;
         rsp_data = head.data;
         rsp_attr_last = head.attr_last;
         rsp_status = ST_OK;
      end else begin
         rsp_kind = 1'b1;
         rsp_attr_type = '0;
         rsp_byte_index = '0;
         rsp_data = '0;
         rsp_attr_last = 1'b0;
         rsp_status = head.status;
      end
      rsp_msg_type = head.msg_type;
      rsp_msg_len = head.msg_len;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
         half_ff <= 1'b0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + AW'(1);
         if (pop) rp_ff <= rp_ff + AW'(1);
         cnt_ff <= cnt_in;
         half_ff <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) q_ff[wp_ff] <= wr_item;
   end
endmodule

### hdl/stun_message_attribute_parser.sv
`timescale 1ns / 1ps
// Parses a STUN message one byte per beat: the front part keeps the 20-byte
// header, walks the padded attributes and XOR-decodes the mapped address byte
// by byte, and a queue that holds three beats feeds the result channel.
// One input beat is taken every cycle while the queue has room, and its result
// is registered in the queue before it is offered. A final byte that falls
// inside an attribute value gives two result beats, the value byte and then
// the status. Registers: 0 max_len, 1 xor_addr_type.
module stun_message_attribute_parser import smap_pkg::*; #(
   parameter int MAX_MSG_BYTES = DEF_MAX_MSG_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [15:0] rsp_attr_type,
   output logic [9:0]  rsp_byte_index,
   output logic [7:0]  rsp_data,
   output logic        rsp_attr_last,
   output logic [15:0] rsp_msg_type,
   output logic [15:0] rsp_msg_len,
   output logic [2:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);
   logic [10:0] max_len_ff;
   logic [15:0] xtype_ff;
   logic        wr_en, q_full;
   work_type    wr_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= RST_MAX_LEN;
         xtype_ff <= RST_XOR_TYPE;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_LEN: max_len_ff <= csr_data[10:0];
            CSR_XOR_TYPE: xtype_ff <= csr_data;
            default: ;
         endcase
      end
   end

   smap_front #(.MAX_MSG_BYTES(MAX_MSG_BYTES)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready),
      .in_byte(req_in_byte), .in_last(req_in_last), .max_len(max_len_ff),
      .xor_type(xtype_ff), .wr_en, .wr_item, .q_full
   );

   smap_back u_back (
      .clock, .reset, .wr_en, .wr_item, .q_full, .rsp_valid, .rsp_ready,
      .rsp_kind, .rsp_attr_type, .rsp_byte_index, .rsp_data, .rsp_attr_last,
      .rsp_msg_type, .rsp_msg_len, .rsp_status
   );
endmodule

### hdl/smap_checker.sv
`timescale 1ns / 1ps
module smap_checker import smap_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_data,
   input logic       rsp_attr_last
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped while stalled");
   a_st: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_status <= ST_TRUNC && !rsp_attr_last)
      else $error("bad status beat");
   a_val: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_status == ST_OK)
      else $error("value beat carries status");
endmodule

bind stun_message_attribute_parser smap_checker u_chk (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_kind, .rsp_status, .rsp_data,
   .rsp_attr_last
);
